/* rtl/core/lsr_pkg.sv */
package lsr_pkg;

   localparam int COORD_W = 6;
   localparam int COLOR_W = 8;
   localparam int CSR_W   = 7;
   localparam int CSR_IDX_W = 2;
   localparam int ERR_W   = 14;

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COLOR_MODE   = 2'd2;

   localparam logic [CSR_W-1:0] IMAGE_WIDTH_RST  = 7'd64;
   localparam logic [CSR_W-1:0] IMAGE_HEIGHT_RST = 7'd64;
   localparam logic             COLOR_MODE_RST   = 1'b1;

   localparam int QDEPTH = 2;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_OUTSIDE = 2'd1,
      ST_ORDER   = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_ERROR,
      BK_COLUMN,
      BK_STEP
   } back_state_type;

   typedef struct packed {
      status_type           status;
      logic [COORD_W-1:0]   x_start;
      logic [COORD_W-1:0]   y_start;
      logic [COORD_W-1:0]   x_end;
      logic [COORD_W-1:0]   y_end;
      logic [COLOR_W-1:0]   red;
      logic [COLOR_W-1:0]   green;
      logic [COLOR_W-1:0]   blue;
      logic                 all_channels;
   } cmd_type;

   typedef struct packed {
      logic [COORD_W-1:0]   col_x;
      logic [COORD_W-1:0]   row_first;
      logic [COORD_W-1:0]   row_last;
      logic [COLOR_W-1:0]   out_red;
      logic [COLOR_W-1:0]   out_green;
      logic [COLOR_W-1:0]   out_blue;
      logic                 all_channels;
      status_type           status;
      logic                 last;
   } rsp_type;

endpackage

/* rtl/core/lsr_if.sv */
interface lsr_req_if;
   logic       valid;
   logic       ready;
   logic [5:0] x_start;
   logic [5:0] y_start;
   logic [5:0] x_end;
   logic [5:0] y_end;
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;

   modport source (output valid, x_start, y_start, x_end, y_end, red, green, blue,
                   input ready);
   modport sink (input valid, x_start, y_start, x_end, y_end, red, green, blue,
                 output ready);
endinterface

interface lsr_rsp_if;
   logic       valid;
   logic       ready;
   logic [5:0] col_x;
   logic [5:0] row_first;
   logic [5:0] row_last;
   logic [7:0] out_red;
   logic [7:0] out_green;
   logic [7:0] out_blue;
   logic       all_channels;
   logic [1:0] status;
   logic       last;

   modport source (output valid, col_x, row_first, row_last, out_red, out_green,
                   out_blue, all_channels, status, last, input ready);
   modport sink (input valid, col_x, row_first, row_last, out_red, out_green,
                 out_blue, all_channels, status, last, output ready);
endinterface

/* rtl/core/lsr_front.sv */
module lsr_front #(
   parameter int MAX_WIDTH  = 64,
   parameter int MAX_HEIGHT = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   lsr_req_if.sink                       req,
   input  logic                          csr_we,
   input  logic [lsr_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [lsr_pkg::CSR_W-1:0]     csr_wdata,
   input  logic                          q_full,
   output logic                          q_push,
   output lsr_pkg::cmd_type              q_cmd
);
   import lsr_pkg::*;

   logic [CSR_W-1:0] width_ff, width_in;
   logic [CSR_W-1:0] height_ff, height_in;
   logic             mode_ff, mode_in;
   logic             outside;
   logic             order;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      mode_in   = mode_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_IMAGE_WIDTH:  width_in  = csr_wdata;
            CSR_IMAGE_HEIGHT: height_in = csr_wdata;
            CSR_COLOR_MODE:   mode_in   = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= IMAGE_WIDTH_RST;
         height_ff <= IMAGE_HEIGHT_RST;
         mode_ff   <= COLOR_MODE_RST;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         mode_ff   <= mode_in;
      end
   end

   always_comb begin
      outside = ({1'b0, req.x_end} >= width_ff) || (int'(req.x_end) >= MAX_WIDTH) ||
                ({1'b0, req.y_end} >= height_ff) || (int'(req.y_end) >= MAX_HEIGHT);
      order   = (req.x_start > req.x_end) || (req.y_start > req.y_end);
   end

   assign req.ready = !q_full;
   assign q_push    = req.valid && !q_full;

   always_comb begin
      q_cmd.status       = outside ? ST_OUTSIDE : (order ? ST_ORDER : ST_OK);
      q_cmd.x_start      = req.x_start;
      q_cmd.y_start      = req.y_start;
      q_cmd.x_end        = req.x_end;
      q_cmd.y_end        = req.y_end;
      q_cmd.red          = req.red;
      q_cmd.green        = mode_ff ? req.green : '0;
      q_cmd.blue         = mode_ff ? req.blue : '0;
      q_cmd.all_channels = mode_ff;
   end

endmodule

/* rtl/core/lsr_queue.sv */
module lsr_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  lsr_pkg::cmd_type push_cmd,
   output logic             full,
   input  logic             pop,
   output logic             empty,
   output lsr_pkg::cmd_type pop_cmd
);
   import lsr_pkg::*;

   cmd_type           entry_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   assign full    = (count_ff == QCNT_W'(QDEPTH));
   assign empty   = (count_ff == '0);
   assign pop_cmd = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

`ifndef ASSERT_OFF
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full && !pop |-> !push)
      else $error("queue push while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      empty |-> !pop)
      else $error("queue pop while empty");
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue count out of step");
`endif

endmodule

/* rtl/core/lsr_back.sv */
module lsr_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_empty,
   input  lsr_pkg::cmd_type q_cmd,
   output logic             q_pop,
   lsr_rsp_if.source        rsp
);
   import lsr_pkg::*;

   back_state_type            state_ff, state_in;
   cmd_type                   cmd_ff, cmd_in;
   logic [COORD_W-1:0]        x_ff, x_in;
   logic [COORD_W-1:0]        y_ff, y_in;
   logic [COORD_W-1:0]        first_ff, first_in;
   logic [COORD_W-1:0]        span_ff, span_in;
   logic signed [ERR_W-1:0]   e_ff, e_in;
   rsp_type                   rsp_ff, rsp_in;
   logic                      rsp_valid_ff, rsp_valid_in;

   logic [COORD_W-1:0]        dy;
   logic [COORD_W-1:0]        dx_new;
   logic                      out_free;
   logic                      step_ok;
   logic                      at_end;
   logic                      col_start;
   logic                      row_step;
   logic                      emit_span;
   logic                      emit_err;

   assign dy       = cmd_ff.y_end - cmd_ff.y_start;
   assign dx_new   = q_cmd.x_end - q_cmd.x_start;
   assign out_free = !rsp_valid_ff || rsp.ready;
   assign at_end   = (x_ff == cmd_ff.x_end);
   assign step_ok  = ($signed({e_ff, 1'b0}) > $signed({{(ERR_W - COORD_W + 1){1'b0}}, span_ff}))
                     && (y_ff < cmd_ff.y_end);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (!q_empty) begin
               state_in = (q_cmd.status == ST_OK) ? BK_COLUMN : BK_ERROR;
            end
         end
         BK_ERROR: begin
            if (out_free) begin
               state_in = BK_IDLE;
            end
         end
         BK_COLUMN: state_in = BK_STEP;
         BK_STEP: begin
            if (!step_ok && out_free) begin
               state_in = at_end ? BK_IDLE : BK_COLUMN;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_comb begin
      q_pop     = 1'b0;
      col_start = 1'b0;
      row_step  = 1'b0;
      emit_span = 1'b0;
      emit_err  = 1'b0;
      case (state_ff)
         BK_IDLE:   q_pop     = !q_empty;
         BK_ERROR:  emit_err  = out_free;
         BK_COLUMN: col_start = 1'b1;
         BK_STEP: begin
            row_step  = step_ok;
            emit_span = !step_ok && out_free;
         end
         default: ;
      endcase
   end

   always_comb begin
      cmd_in       = q_pop ? q_cmd : cmd_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      e_in         = e_ff;
      span_in      = span_ff;
      first_in     = col_start ? y_ff : first_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      if (q_pop) begin
         x_in    = q_cmd.x_start;
         y_in    = q_cmd.y_start;
         e_in    = '0;
         span_in = (dx_new == '0) ? COORD_W'(1) : dx_new;
      end
      if (col_start) begin
         e_in = e_ff + $signed({{(ERR_W - COORD_W){1'b0}}, dy});
      end
      if (row_step) begin
         y_in = y_ff + 1'b1;
         e_in = e_ff - $signed({{(ERR_W - COORD_W){1'b0}}, span_ff});
      end
      if (emit_span) begin
         x_in                = at_end ? x_ff : x_ff + 1'b1;
         rsp_in.col_x        = x_ff;
         rsp_in.row_first    = first_ff;
         rsp_in.row_last     = y_ff;
         rsp_in.out_red      = cmd_ff.red;
         rsp_in.out_green    = cmd_ff.green;
         rsp_in.out_blue     = cmd_ff.blue;
         rsp_in.all_channels = cmd_ff.all_channels;
         rsp_in.status       = ST_OK;
         rsp_in.last         = at_end;
         rsp_valid_in        = 1'b1;
      end
      if (emit_err) begin
         rsp_in        = '0;
         rsp_in.status = cmd_ff.status;
         rsp_in.last   = 1'b1;
         rsp_valid_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff   <= cmd_in;
      x_ff     <= x_in;
      y_ff     <= y_in;
      e_ff     <= e_in;
      span_ff  <= span_in;
      first_ff <= first_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.col_x        = rsp_ff.col_x;
   assign rsp.row_first    = rsp_ff.row_first;
   assign rsp.row_last     = rsp_ff.row_last;
   assign rsp.out_red      = rsp_ff.out_red;
   assign rsp.out_green    = rsp_ff.out_green;
   assign rsp.out_blue     = rsp_ff.out_blue;
   assign rsp.all_channels = rsp_ff.all_channels;
   assign rsp.status       = rsp_ff.status;
   assign rsp.last         = rsp_ff.last;

`ifndef ASSERT_OFF
   a_span_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.status == ST_OK |-> rsp_ff.row_last >= rsp_ff.row_first)
      else $error("span rows out of order");
   a_error_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.status != ST_OK |-> rsp_ff.last)
      else $error("error item without last");
   a_row_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == BK_STEP |-> y_ff <= cmd_ff.y_end)
      else $error("row passed line end");
   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> state_ff == BK_COLUMN || state_ff == BK_ERROR)
      else $error("pop outside idle");
`endif

endmodule

/* rtl/core/line_span_rasterizer_top.sv */
// Flow: a command reaches the queue in the accept cycle; when the walk is idle it is
// popped, and each column passes the column and step states, staying in the step
// state for its row steps and while the response is held; an error command passes
// the error state only. A new command is popped only once the walk is back in idle.
// Reset: synchronous, active high; clears the queue and walk state and loads
// image_width 64, image_height 64, color_mode 1.
module line_span_rasterizer_top #(
   parameter int MAX_WIDTH  = 64,
   parameter int MAX_HEIGHT = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   lsr_req_if.sink                       req_ch,
   lsr_rsp_if.source                     rsp_ch,
   input  logic                          csr_we,
   input  logic [lsr_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [lsr_pkg::CSR_W-1:0]     csr_wdata
);
   import lsr_pkg::*;

   logic    q_push;
   logic    q_pop;
   logic    q_full;
   logic    q_empty;
   cmd_type push_cmd;
   cmd_type pop_cmd;

   lsr_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_cmd     (push_cmd)
   );

   lsr_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (push_cmd),
      .full     (q_full),
      .pop      (q_pop),
      .empty    (q_empty),
      .pop_cmd  (pop_cmd)
   );

   lsr_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_empty (q_empty),
      .q_cmd   (pop_cmd),
      .q_pop   (q_pop),
      .rsp     (rsp_ch)
   );

endmodule

/* tb/tb.sv */
module tb;
   import lsr_pkg::*;

   localparam int IMG_MAX_W   = 64;
   localparam int IMG_MAX_H   = 64;
   localparam int CYCLE_LIMIT = 6_000_000;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   typedef struct packed {
      logic [COORD_W-1:0] xs;
      logic [COORD_W-1:0] ys;
      logic [COORD_W-1:0] xe;
      logic [COORD_W-1:0] ye;
      logic [COLOR_W-1:0] red;
      logic [COLOR_W-1:0] green;
      logic [COLOR_W-1:0] blue;
   } line_cmd_type;

   logic                 clock;
   logic                 reset;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0]     csr_wdata;

   lsr_req_if req_ch ();
   lsr_rsp_if rsp_ch ();

   line_span_rasterizer_top #(
      .MAX_WIDTH  (IMG_MAX_W),
      .MAX_HEIGHT (IMG_MAX_H)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   logic [CSR_W-1:0] img_width;
   logic [CSR_W-1:0] img_height;
   logic             color_mode;

   rsp_type span_q[$];

   bit quiet;
   int ready_hold;
   int cycle_cnt;
   int fail_cnt;
   int line_cnt;
   int span_cnt;
   int reject_cnt;
   int cfg_cnt;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_cnt++;
      if (cycle_cnt > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
                  span_q.size());
         $display("FAIL");
         $finish;
      end
   end

   function automatic int idle_len();
      if ($urandom_range(0, 99) < 85) return int'($urandom_range(1, 3));
      return int'($urandom_range(4, 40));
   endfunction

   function automatic int gap_len();
      if (quiet || $urandom_range(0, 99) < 50) return 0;
      return idle_len();
   endfunction

   always @(negedge clock) begin
      if (quiet) begin
         rsp_ch.ready = 1'b1;
         ready_hold = 0;
      end else if (ready_hold > 0) begin
         rsp_ch.ready = 1'b0;
         ready_hold--;
      end else begin
         rsp_ch.ready = 1'b1;
         if ($urandom_range(0, 99) < 35) ready_hold = idle_len();
      end
   end

   function automatic int eff_width();
      return (int'(img_width) > IMG_MAX_W) ? IMG_MAX_W : int'(img_width);
   endfunction

   function automatic int eff_height();
      return (int'(img_height) > IMG_MAX_H) ? IMG_MAX_H : int'(img_height);
   endfunction

   function automatic void predict_spans(line_cmd_type c);
      rsp_type s;
      int dy;
      int span;
      int err;
      int row;
      s = '0;
      s.last = 1'b1;
      if (int'(c.xe) >= eff_width() || int'(c.ye) >= eff_height()) begin
         s.status = ST_OUTSIDE;
         span_q.push_back(s);
      end else if (c.xs > c.xe || c.ys > c.ye) begin
         s.status = ST_ORDER;
         span_q.push_back(s);
      end else begin
         dy   = int'(c.ye) - int'(c.ys);
         span = int'(c.xe) - int'(c.xs);
         if (span == 0) span = 1;
         err  = 0;
         row  = int'(c.ys);
         for (int x = int'(c.xs); x <= int'(c.xe); x++) begin
            s.col_x     = COORD_W'(x);
            s.row_first = COORD_W'(row);
            err += dy;
            while (2 * err > span && row < int'(c.ye)) begin
               row++;
               err -= span;
            end
            s.row_last     = COORD_W'(row);
            s.out_red      = c.red;
            s.out_green    = color_mode ? c.green : '0;
            s.out_blue     = color_mode ? c.blue : '0;
            s.all_channels = color_mode;
            s.status       = ST_OK;
            s.last         = (x == int'(c.xe));
            span_q.push_back(s);
         end
      end
   endfunction

   function automatic void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
         fail_cnt++;
      end
   endfunction

   always @(posedge clock) begin : result_check
      rsp_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (span_q.size() == 0) begin
            $display("%0t: unexpected result, expected none, got col %0d status %0d",
                     $time, rsp_ch.col_x, rsp_ch.status);
            fail_cnt++;
         end else begin
            want = span_q.pop_front();
            if (want.status == ST_OK) span_cnt++;
            else reject_cnt++;
            check_field("col_x", 32'(want.col_x), 32'(rsp_ch.col_x));
            check_field("row_first", 32'(want.row_first), 32'(rsp_ch.row_first));
            check_field("row_last", 32'(want.row_last), 32'(rsp_ch.row_last));
            check_field("out_red", 32'(want.out_red), 32'(rsp_ch.out_red));
            check_field("out_green", 32'(want.out_green), 32'(rsp_ch.out_green));
            check_field("out_blue", 32'(want.out_blue), 32'(rsp_ch.out_blue));
            check_field("all_channels", 32'(want.all_channels),
                        32'(rsp_ch.all_channels));
            check_field("status", 32'(want.status), 32'(rsp_ch.status));
            check_field("last", 32'(want.last), 32'(rsp_ch.last));
         end
      end
   end

   function automatic line_cmd_type make_line(int xs, int ys, int xe, int ye,
                                              int red, int green, int blue);
      line_cmd_type c;
      c.xs    = COORD_W'(xs);
      c.ys    = COORD_W'(ys);
      c.xe    = COORD_W'(xe);
      c.ye    = COORD_W'(ye);
      c.red   = COLOR_W'(red);
      c.green = COLOR_W'(green);
      c.blue  = COLOR_W'(blue);
      return c;
   endfunction

   task automatic send_line(line_cmd_type c);
      int gap;
      gap = gap_len();
      if (gap > 0) begin
         @(negedge clock);
         req_ch.valid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_ch.x_start = c.xs;
      req_ch.y_start = c.ys;
      req_ch.x_end   = c.xe;
      req_ch.y_end   = c.ye;
      req_ch.red     = c.red;
      req_ch.green   = c.green;
      req_ch.blue    = c.blue;
      req_ch.valid   = 1'b1;
      do @(posedge clock); while (!req_ch.ready);
      predict_spans(c);
      line_cnt++;
   endtask

   task automatic wait_drain();
      @(negedge clock);
      req_ch.valid = 1'b0;
      while (span_q.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_W-1:0] data);
      wait_drain();
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      @(negedge clock);
      csr_we = 1'b0;
      case (idx)
         CSR_IMAGE_WIDTH:  img_width = data;
         CSR_IMAGE_HEIGHT: img_height = data;
         CSR_COLOR_MODE:   color_mode = data[0];
         default: ;
      endcase
      cfg_cnt++;
   endtask

   task automatic test_line_shapes();
      send_line(make_line(0, 0, 0, 0, 8'hFF, 8'hFF, 8'hFF));
      send_line(make_line(0, 0, 63, 63, 8'h00, 8'h00, 8'h00));
      send_line(make_line(0, 0, 63, 0, 8'hAA, 8'h55, 8'hAA));
      send_line(make_line(5, 0, 5, 63, 8'h55, 8'hAA, 8'h55));
      send_line(make_line(63, 63, 63, 63, 8'h01, 8'h80, 8'h7F));
      send_line(make_line(0, 0, 3, 63, 8'hFF, 8'h00, 8'hFF));
      send_line(make_line(0, 10, 63, 12, 8'h00, 8'hFF, 8'h00));
      send_line(make_line(20, 40, 27, 45, 8'h3C, 8'hC3, 8'h96));
   endtask

   task automatic test_command_errors();
      write_reg(CSR_IMAGE_WIDTH, 7'd10);
      write_reg(CSR_IMAGE_HEIGHT, 7'd12);
      // end outside is checked ahead of the ordering check
      send_line(make_line(0, 0, 10, 5, 8'hFF, 8'hFF, 8'hFF));
      send_line(make_line(0, 0, 4, 12, 8'hFF, 8'hFF, 8'hFF));
      send_line(make_line(63, 63, 63, 63, 8'hFF, 8'hFF, 8'hFF));
      send_line(make_line(7, 0, 6, 3, 8'h12, 8'h34, 8'h56));
      send_line(make_line(2, 9, 6, 8, 8'h12, 8'h34, 8'h56));
      send_line(make_line(9, 11, 0, 0, 8'h12, 8'h34, 8'h56));
   endtask

   task automatic test_register_settings();
      write_reg(CSR_IMAGE_WIDTH, 7'd0);
      send_line(make_line(0, 0, 0, 0, 8'hFF, 8'hFF, 8'hFF));
      write_reg(CSR_IMAGE_WIDTH, 7'd127);
      write_reg(CSR_IMAGE_HEIGHT, 7'd127);
      send_line(make_line(0, 0, 63, 63, 8'h81, 8'h42, 8'h24));
      // only bit 0 of the color mode data counts
      write_reg(CSR_COLOR_MODE, 7'h7E);
      send_line(make_line(2, 3, 9, 5, 8'hAA, 8'h55, 8'hFF));
      write_reg(CSR_IMAGE_WIDTH, 7'd1);
      write_reg(CSR_IMAGE_HEIGHT, 7'd1);
      send_line(make_line(0, 0, 0, 0, 8'hAA, 8'h55, 8'hFF));
      send_line(make_line(0, 0, 1, 0, 8'hAA, 8'h55, 8'hFF));
      send_line(make_line(0, 0, 0, 1, 8'hAA, 8'h55, 8'hFF));
      // unmapped index must leave the image size alone
      write_reg(CSR_UNUSED, 7'd0);
      send_line(make_line(0, 0, 0, 0, 8'h0F, 8'hF0, 8'h33));
      write_reg(CSR_IMAGE_WIDTH, 7'd64);
      write_reg(CSR_IMAGE_HEIGHT, 7'd64);
      write_reg(CSR_COLOR_MODE, 7'd1);
   endtask

   function automatic logic [CSR_W-1:0] pick_size();
      int r;
      r = int'($urandom_range(0, 99));
      if (r < 40) return 7'd64;
      if (r < 50) return 7'd127;
      if (r < 60) return CSR_W'($urandom_range(65, 126));
      if (r < 70) return 7'd1;
      return CSR_W'($urandom_range(2, 63));
   endfunction

   function automatic line_cmd_type random_line();
      line_cmd_type c;
      int w;
      int h;
      int dx;
      int dy;
      int r;
      logic [COORD_W-1:0] t;
      w = eff_width();
      h = eff_height();
      c.red   = COLOR_W'($urandom_range(0, 255));
      c.green = COLOR_W'($urandom_range(0, 255));
      c.blue  = COLOR_W'($urandom_range(0, 255));
      r = int'($urandom_range(0, 99));
      if (r >= 85 && r < 93) begin
         c.xs = COORD_W'($urandom_range(0, 63));
         c.ys = COORD_W'($urandom_range(0, 63));
         c.xe = COORD_W'($urandom_range(0, 63));
         c.ye = COORD_W'($urandom_range(0, 63));
         return c;
      end
      dx = ($urandom_range(0, 99) < 80) ? int'($urandom_range(0, (w - 1 < 7) ? w - 1 : 7))
                                        : int'($urandom_range(0, w - 1));
      dy = ($urandom_range(0, 99) < 70) ? int'($urandom_range(0, (h - 1 < 15) ? h - 1 : 15))
                                        : int'($urandom_range(0, h - 1));
      c.xs = COORD_W'($urandom_range(0, w - 1 - dx));
      c.xe = COORD_W'(int'(c.xs) + dx);
      c.ys = COORD_W'($urandom_range(0, h - 1 - dy));
      c.ye = COORD_W'(int'(c.ys) + dy);
      if (r >= 93) begin
         // break the command: swap an axis or push the end out of the image
         if (w < 64 && $urandom_range(0, 1)) c.xe = COORD_W'($urandom_range(w, 63));
         else if (h < 64 && $urandom_range(0, 1)) c.ye = COORD_W'($urandom_range(h, 63));
         else if (dx > 0) begin
            t = c.xs; c.xs = c.xe; c.xe = t;
         end else if (dy > 0) begin
            t = c.ys; c.ys = c.ye; c.ye = t;
         end
      end
      return c;
   endfunction

   task automatic test_random_lines();
      for (int phase = 0; phase < 8; phase++) begin
         write_reg(CSR_IMAGE_WIDTH, (phase == 0) ? 7'd64 : pick_size());
         write_reg(CSR_IMAGE_HEIGHT, (phase == 0) ? 7'd64 : pick_size());
         write_reg(CSR_COLOR_MODE, CSR_W'($urandom_range(0, 127)));
         quiet = (phase == 2 || phase == 6);
         for (int i = 0; i < 60; i++) send_line(random_line());
      end
      quiet = 1'b0;
   endtask

   initial begin
      clock          = 1'b0;
      reset          = 1'b1;
      csr_we         = 1'b0;
      csr_index      = '0;
      csr_wdata      = '0;
      req_ch.valid   = 1'b0;
      req_ch.x_start = '0;
      req_ch.y_start = '0;
      req_ch.x_end   = '0;
      req_ch.y_end   = '0;
      req_ch.red     = '0;
      req_ch.green   = '0;
      req_ch.blue    = '0;
      img_width      = IMAGE_WIDTH_RST;
      img_height     = IMAGE_HEIGHT_RST;
      color_mode     = COLOR_MODE_RST;
      quiet          = 1'b0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_line_shapes();
      test_command_errors();
      test_register_settings();
      test_random_lines();

      wait_drain();
      repeat (16) @(posedge clock);
      $display("sent %0d line commands over %0d register writes", line_cnt, cfg_cnt);
      $display("checked %0d spans and %0d rejected commands, %0d mismatches",
               span_cnt, reject_cnt, fail_cnt);
      if (fail_cnt == 0 && span_q.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
